[src/icmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP echo responder package
// Shared types and constants for the echo reply builder.
// ----------------------------------------------------------------------------
package icmp_pkg;
   localparam int DATA_W  = 64;
   localparam int BYTES_W = 4;
   localparam int MAC_W   = 48;

   localparam logic [7:0] IP_VER_IHL = 8'h45;
   localparam logic [7:0] IP_TTL     = 8'd64;
   localparam logic [7:0] IP_PROTO   = 8'd1;
   localparam logic [7:0] ICMP_REQ   = 8'd8;
   localparam logic [7:0] ETYPE_HI   = 8'h08;
   localparam logic [15:0] SUM_MASK  = 16'hffff;

   typedef struct packed {
      logic [DATA_W-1:0]  data;
      logic [BYTES_W-1:0] bytes;
      logic               last;
   } word_type;
endpackage

[src/icmp_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame word stream interface
// Valid/ready channel carrying one frame word.
// ----------------------------------------------------------------------------
interface icmp_stream_if
   import icmp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  data;
   logic [BYTES_W-1:0] bytes;
   logic               last;
   modport source (output valid, data, bytes, last, input ready);
   modport sink (input valid, data, bytes, last, output ready);
endinterface

interface icmp_csr_if
   import icmp_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [MAC_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[src/icmp_echo_reply_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP echo reply builder
// Stores a received frame, checks for an echo request, emits an echo reply.
// ----------------------------------------------------------------------------
// Receive: each word goes through accept, one write per byte and a wrap-up;
// the last word adds a check step. req is ready only in the idle state.
// Reply: IP header sum, then ICMP sum through a shared 17-bit adder, then
// the reply is assembled byte by byte and sent per word (held under rsp stalls).
// Synchronous reset clears control state and own_mac; the store is not cleared.
module icmp_echo_reply_builder
   import icmp_pkg::*;
   #(parameter int MAX_FRAME = 512)
   (
   input  logic clock,
   input  logic reset,
   icmp_stream_if.sink   req,
   icmp_stream_if.source rsp,
   icmp_csr_if.sink      csr
   );

   localparam int AW = $clog2(MAX_FRAME);
   localparam int CW = $clog2(MAX_FRAME + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_WR, S_CHK, S_HDR, S_IRD, S_ISUM, S_OUT, S_OWAIT, S_OSEND
   } state_type;

   state_type state_ff;
   logic [7:0]  mem [MAX_FRAME];
   logic [7:0]  rd_ff;
   logic [AW-1:0] raddr;
   logic        rd_en;
   logic [MAC_W-1:0] mac_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic [3:0]  wcnt_ff, widx_ff;
   logic        wlast_ff;
   logic [CW-1:0] cnt_ff;
   logic        ovf_ff;
   logic [15:0] tl_ff;
   logic [7:0]  proto_ff, type_ff;
   logic [CW:0] pos_ff;
   logic [16:0] sum_ff;
   logic [15:0] ipck_ff, icck_ff;
   logic [47:0] dmac_ff;
   logic [31:0] sip_ff, dip_ff;
   logic [DATA_W-1:0] wbuf_ff;
   logic [3:0]  wb_ff;
   logic [DATA_W-1:0] obuf_ff;
   logic [3:0]  ob_ff;
   logic        ovalid_ff, olast_ff;
   logic [CW:0] len;
   logic [7:0]  hb;
   logic [16:0] add;

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = ovalid_ff;
   assign rsp.data  = obuf_ff;
   assign rsp.bytes = ob_ff;
   assign rsp.last  = olast_ff;
   assign len = (CW+1)'(tl_ff) + (CW+1)'(14);

   // reply header byte at pos (before checksums where noted)
   function automatic logic [7:0] hdr_byte(input logic [CW:0] p);
      logic [7:0] b;
      b = 8'd0;
      if (p < 6) b = dmac_ff[47 - 8*p[2:0] -: 8];
      else if (p < 12) b = mac_ff[47 - 8*(p[3:0]-6) -: 8];
      else if (p == 12) b = ETYPE_HI;
      else if (p == 14) b = IP_VER_IHL;
      else if (p == 16) b = tl_ff[15:8];
      else if (p == 17) b = tl_ff[7:0];
      else if (p == 22) b = IP_TTL;
      else if (p == 23) b = IP_PROTO;
      else if (p == 24) b = ipck_ff[15:8];
      else if (p == 25) b = ipck_ff[7:0];
      else if (p >= 26 && p < 30) b = dip_ff[31 - 8*(p[4:0]-26) -: 8];
      else if (p >= 30 && p < 34) b = sip_ff[31 - 8*(p[5:0]-30) -: 8];
      else if (p == 36) b = icck_ff[15:8];
      else if (p == 37) b = icck_ff[7:0];
      return b;
   endfunction

   always_comb hb = hdr_byte(pos_ff);
   // shared one's complement adder; odd positions are low bytes
   always_comb begin
      logic [7:0] v;
      v = (state_ff == S_HDR) ? hb : rd_ff;
      if (state_ff == S_ISUM && pos_ff <= 37 && pos_ff != 35) v = 8'd0;
      add = {1'b0, sum_ff[15:0]} + {16'd0, sum_ff[16]} +
            (pos_ff[0] ? {9'd0, v} : {1'b0, v, 8'd0});
   end

   always_comb begin
      rd_en = 1'b1;
      raddr = AW'(pos_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WR && !ovf_ff && widx_ff != wcnt_ff)
         mem[AW'(cnt_ff)] <= wdata_ff[8*widx_ff[2:0] +: 8];
      if (rd_en) rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; mac_ff <= '0; cnt_ff <= '0; ovf_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         if (csr.valid) mac_ff <= csr.data;
         case (state_ff)
            S_IDLE: if (req.valid) begin
               wdata_ff <= req.data;
               wcnt_ff  <= (req.bytes > 4'd8) ? 4'd8 : req.bytes;
               wlast_ff <= req.last;
               widx_ff  <= '0;
               if (!ovf_ff && (CW+1)'(cnt_ff) + (CW+1)'((req.bytes > 4'd8) ? 4'd8 : req.bytes)
                   > (CW+1)'(MAX_FRAME)) ovf_ff <= 1'b1;
               state_ff <= S_WR;
            end
            S_WR: begin
               if (ovf_ff || widx_ff == wcnt_ff) begin
                  if (wlast_ff) begin
                     pos_ff <= (CW+1)'(6); state_ff <= S_CHK; sum_ff <= '0;
                  end else state_ff <= S_IDLE;
               end else begin
                  // capture header fields as they pass
                  case (cnt_ff)
                     CW'(16): tl_ff[15:8] <= wdata_ff[8*widx_ff[2:0] +: 8];
                     CW'(17): tl_ff[7:0] <= wdata_ff[8*widx_ff[2:0] +: 8];
                     CW'(23): proto_ff <= wdata_ff[8*widx_ff[2:0] +: 8];
                     CW'(34): type_ff <= wdata_ff[8*widx_ff[2:0] +: 8];
                     default: ;
                  endcase
                  if (cnt_ff >= CW'(6) && cnt_ff < CW'(12))
                     dmac_ff <= {dmac_ff[39:0], wdata_ff[8*widx_ff[2:0] +: 8]};
                  if (cnt_ff >= CW'(26) && cnt_ff < CW'(30))
                     sip_ff <= {sip_ff[23:0], wdata_ff[8*widx_ff[2:0] +: 8]};
                  if (cnt_ff >= CW'(30) && cnt_ff < CW'(34))
                     dip_ff <= {dip_ff[23:0], wdata_ff[8*widx_ff[2:0] +: 8]};
                  cnt_ff <= cnt_ff + 1'b1;
                  widx_ff <= widx_ff + 1'b1;
               end
            end
            S_CHK: begin
               if (!ovf_ff && cnt_ff >= CW'(42) && tl_ff >= 16'd28 &&
                   (17'(tl_ff) + 17'd14) <= 17'(cnt_ff) &&
                   proto_ff == IP_PROTO && type_ff == ICMP_REQ) begin
                  ipck_ff <= '0; icck_ff <= '0;
                  pos_ff <= (CW+1)'(14); state_ff <= S_HDR;
               end else state_ff <= S_IDLE;
               cnt_ff <= '0; ovf_ff <= 1'b0;
            end
            S_HDR: begin
               if (pos_ff == (CW+1)'(33)) begin
                  pos_ff <= (CW+1)'(34); state_ff <= S_IRD; sum_ff <= '0;
                  ipck_ff <= ~(add[15:0] + {15'd0, add[16]}) & SUM_MASK;
               end else begin
                  sum_ff <= add;
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            S_IRD: state_ff <= S_ISUM;   // read latency
            S_ISUM: begin
               sum_ff <= add;
               if (pos_ff + 1'b1 == len) begin
                  icck_ff <= ~(add[15:0] + {15'd0, add[16]}) & SUM_MASK;
                  pos_ff <= '0; wb_ff <= '0; wbuf_ff <= '0; state_ff <= S_OUT;
               end else begin
                  pos_ff <= pos_ff + 1'b1; state_ff <= S_IRD;
               end
            end
            S_OUT: state_ff <= S_OWAIT;  // read latency
            S_OWAIT: begin
               wbuf_ff[8*wb_ff[2:0] +: 8] <=
                  (pos_ff < 38 && !(pos_ff == 35)) ? hb : rd_ff;
               if (wb_ff == 4'd7 || pos_ff + 1'b1 == len) begin
                  state_ff <= S_OSEND;
               end else begin
                  wb_ff <= wb_ff + 1'b1; pos_ff <= pos_ff + 1'b1; state_ff <= S_OUT;
               end
            end
            S_OSEND: if (!ovalid_ff || rsp.ready) begin
               // word handed to the output register
               wbuf_ff <= '0; wb_ff <= '0;
               if (pos_ff + 1'b1 == len) begin
                  state_ff <= S_IDLE;
               end else begin
                  pos_ff <= pos_ff + 1'b1; state_ff <= S_OUT;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_OSEND && (!ovalid_ff || rsp.ready)) begin
            ovalid_ff <= 1'b1;
            obuf_ff   <= wbuf_ff;
            ob_ff     <= wb_ff + 1'b1;
            olast_ff  <= (pos_ff + 1'b1 == len);
         end else if (rsp.ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.last |-> rsp.bytes == 4'd8)
      else $error("short non-final reply word");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data) &&
         $stable(rsp.bytes) && $stable(rsp.last))
      else $error("reply word changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHK |=> cnt_ff == '0)
      else $error("count not cleared at frame end");
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP echo reply builder testbench
// Sends Ethernet frames as words: echo requests, malformed, short and
// oversized frames. Each reply word is predicted from a local copy of the
// frame store and station MAC, and compared in order with the reply stream.
// ----------------------------------------------------------------------------
module tb;
   import icmp_pkg::*;

   localparam int MAX_FRAME = 512;
   localparam int SETTLE    = 2400;   // wait after the queues empty, covering reply build and drain

   logic clock;
   logic reset;

   icmp_stream_if req ();
   icmp_stream_if rsp ();
   icmp_csr_if    csr ();

   icmp_echo_reply_builder #(.MAX_FRAME(MAX_FRAME)) uut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr(csr)
   );

   // predictor state
   logic [7:0]       rx_store [MAX_FRAME];
   logic [7:0]       reply_buf [MAX_FRAME];
   int               rx_count;
   bit               rx_overflow;
   logic [MAC_W-1:0] station_mac;

   word_type rx_words [$];
   word_type reply_words [$];
   logic [7:0] frame [$];

   int errors;
   int stall_mode;
   int stall_left;
   int burst_left;
   int gap_left;
   int cyc;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("tb: done, errors");
      $finish;
   end

   function automatic logic [15:0] ones_sum16(int first, int len);
      logic [31:0] s;
      int i;
      s = 0;
      for (i = 0; i + 1 < len; i += 2)
         s += {reply_buf[first + i], reply_buf[first + i + 1]};
      if (len % 2)
         s += {reply_buf[first + len - 1], 8'h00};
      while (s >> 16)
         s = (s & 32'hffff) + (s >> 16);
      return ~s[15:0] & SUM_MASK;
   endfunction

   // update the frame store with one word, queue reply words on a good frame
   task automatic absorb_word(word_type w);
      int n, i, tl, len, pos, cnt;
      logic [15:0] ck;
      word_type o;
      n = (w.bytes > 8) ? 8 : int'(w.bytes);
      if (!rx_overflow) begin
         if (rx_count + n > MAX_FRAME)
            rx_overflow = 1;
         else begin
            for (i = 0; i < n; i++)
               rx_store[rx_count + i] = w.data[8*i +: 8];
            rx_count += n;
         end
      end
      if (!w.last)
         return;
      if (!rx_overflow && rx_count >= 42) begin
         tl = {rx_store[16], rx_store[17]};
         if (tl >= 28 && 14 + tl <= rx_count && rx_store[23] == IP_PROTO
               && rx_store[34] == ICMP_REQ) begin
            len = 14 + tl;
            for (i = 0; i < 6; i++) begin
               reply_buf[i]     = rx_store[6 + i];
               reply_buf[6 + i] = station_mac[40 - 8*i +: 8];
            end
            reply_buf[12] = ETYPE_HI;
            reply_buf[13] = 8'h00;
            reply_buf[14] = IP_VER_IHL;
            reply_buf[15] = 8'h00;
            reply_buf[16] = tl[15:8];
            reply_buf[17] = tl[7:0];
            for (i = 18; i < 22; i++)
               reply_buf[i] = 8'h00;
            reply_buf[22] = IP_TTL;
            reply_buf[23] = IP_PROTO;
            reply_buf[24] = 8'h00;
            reply_buf[25] = 8'h00;
            for (i = 0; i < 4; i++) begin
               reply_buf[26 + i] = rx_store[30 + i];
               reply_buf[30 + i] = rx_store[26 + i];
            end
            ck = ones_sum16(14, 20);
            reply_buf[24] = ck[15:8];
            reply_buf[25] = ck[7:0];
            for (i = 0; i < tl - 20; i++)
               reply_buf[34 + i] = rx_store[34 + i];
            reply_buf[34] = 8'h00;
            reply_buf[36] = 8'h00;
            reply_buf[37] = 8'h00;
            ck = ones_sum16(34, tl - 20);
            reply_buf[36] = ck[15:8];
            reply_buf[37] = ck[7:0];
            for (pos = 0; pos < len; pos += 8) begin
               cnt = (len - pos > 8) ? 8 : len - pos;
               o.data = '0;
               for (i = 0; i < cnt; i++)
                  o.data[8*i +: 8] = reply_buf[pos + i];
               o.bytes = cnt[BYTES_W-1:0];
               o.last  = (pos + cnt >= len);
               reply_words.push_back(o);
            end
         end
      end
      rx_count = 0;
      rx_overflow = 0;
   endtask

   task automatic queue_word(word_type w);
      absorb_word(w);
      rx_words.push_back(w);
   endtask

   // frame of 14+tl+extra random bytes with header fields set
   task automatic make_frame(int tl, int extra, bit proto_ok, bit type_ok);
      int len, i;
      len = 14 + tl + extra;
      frame = {};
      for (i = 0; i < len; i++)
         frame.push_back(8'($urandom_range(0, 255)));
      if (len > 13) begin
         frame[12] = ETYPE_HI;
         frame[13] = 8'h00;
      end
      if (len > 17) begin
         frame[16] = tl[15:8];
         frame[17] = tl[7:0];
      end
      if (len > 23)
         frame[23] = proto_ok ? IP_PROTO : 8'($urandom_range(2, 255));
      if (len > 34)
         frame[34] = type_ok ? ICMP_REQ : 8'($urandom_range(9, 255));
   endtask

   // cut the frame into words of random fill, odd byte codes included
   task automatic send_frame();
      int idx, n, r, code;
      bit tail_empty;
      word_type w;
      idx = 0;
      tail_empty = ($urandom_range(0, 9) == 0);
      while (idx < frame.size()) begin
         r = $urandom_range(0, 19);
         if (r == 0)
            code = 0;
         else if (r < 3)
            code = $urandom_range(9, 15);
         else if (r < 6)
            code = $urandom_range(1, 7);
         else
            code = 8;
         n = (code > 8) ? 8 : code;
         if (n > frame.size() - idx) begin
            n = frame.size() - idx;
            code = n;
         end
         w.data = {$urandom, $urandom};
         for (int i = 0; i < n; i++)
            w.data[8*i +: 8] = frame[idx + i];
         w.bytes = code[BYTES_W-1:0];
         idx += n;
         w.last = (idx >= frame.size()) && !tail_empty;
         queue_word(w);
      end
      if (tail_empty || frame.size() == 0) begin
         w.data  = {$urandom, $urandom};
         w.bytes = '0;
         w.last  = 1'b1;
         queue_word(w);
      end
   endtask

   task automatic frame_out(int tl, int extra, bit proto_ok, bit type_ok);
      make_frame(tl, extra, proto_ok, type_ok);
      send_frame();
   endtask

   task automatic wait_idle();
      while (rx_words.size() != 0 || req.valid || reply_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mac(logic [MAC_W-1:0] mac);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.data  <= mac;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      station_mac = mac;
   endtask

   task automatic random_frames(int count);
      int k, r, tl;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         tl = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 498)
                                            : $urandom_range(28, 90);
         if (r < 70)
            frame_out(tl, $urandom_range(0, 3) == 0 ? $urandom_range(1, 9) : 0,
                      1, 1);
         else if (r < 76)
            frame_out(tl, 0, 0, 1);
         else if (r < 82)
            frame_out(tl, 0, 1, 0);
         else if (r < 87)
            frame_out($urandom_range(0, 27), $urandom_range(20, 40), 1, 1);
         else if (r < 92)
            frame_out(tl, -$urandom_range(1, 10), 1, 1);
         else if (r < 96)
            frame_out($urandom_range(480, 560), $urandom_range(0, 20), 1, 1);
         else
            frame_out($urandom_range(0, 27), 0, 1, 1);
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.data  = '0;
      req.bytes = '0;
      req.last  = 1'b0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.data  = '0;
      errors = 0;
      rx_count = 0;
      rx_overflow = 0;
      station_mac = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_mac(MAC_W'({$urandom, $urandom}));
      // directed frames
      frame_out(28, 0, 1, 1);            // shortest echo
      frame_out(29, 0, 1, 1);            // odd ICMP length
      frame_out(40, 7, 1, 1);            // trailing bytes past the IP length
      frame_out(40, 0, 0, 1);            // not ICMP
      frame_out(40, 0, 1, 0);            // not an echo request
      frame_out(27, 10, 1, 1);           // IP length too small
      frame_out(60, -3, 1, 1);           // truncated
      frame_out(20, 0, 1, 1);            // runt, under 42 bytes
      frame_out(498, 0, 1, 1);           // fills the store exactly
      frame_out(520, 0, 1, 1);           // overflow
      frame_out(28, 0, 1, 1);
      wait_idle();

      write_mac('1);
      random_frames(2);
      wait_idle();
      write_mac('0);
      random_frames(1);
      wait_idle();
      write_mac(MAC_W'({$urandom, $urandom}));
      random_frames(1);
      wait_idle();

      if (errors == 0 && reply_words.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   // sender: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req.valid || req.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req.valid <= 1'b0;
         end else if (rx_words.size() > 0) begin
            word_type w;
            w = rx_words.pop_front();
            req.data  <= w.data;
            req.bytes <= w.bytes;
            req.last  <= w.last;
            req.valid <= 1'b1;
            if (burst_left == 0)
               burst_left = $urandom_range(1, 24);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern and reply word check
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_mode = 0;
         stall_left = 0;
         cyc = 0;
      end else begin
         cyc++;
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 400);
         end
         stall_left--;
         case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= 1'($urandom_range(0, 1));
            2: rsp.ready <= (cyc % 4 == 0);
            default: rsp.ready <= ($urandom_range(0, 7) != 0);
         endcase
         if (rsp.valid && rsp.ready) begin
            if (reply_words.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected reply word data=%h bytes=%0d last=%0b",
                           rsp.data, rsp.bytes, rsp.last);
            end else begin
               word_type e;
               e = reply_words.pop_front();
               if (rsp.data !== e.data || rsp.bytes !== e.bytes
                     || rsp.last !== e.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("reply word mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                              e.data, e.bytes, e.last,
                              rsp.data, rsp.bytes, rsp.last);
               end
            end
         end
      end
   end
endmodule
